### rtl/core/fsd_pkg.sv
// Shared types, constants and arithmetic helpers for the mono dither unit.
// Used by the channel interfaces and by every module under rtl/core.
// No dependencies.
package fsd_pkg;

   // Field and register widths.
   localparam int GRAY_W     = 8;
   localparam int ERR_W      = 11;
   localparam int SUM_W      = 14;
   localparam int PIX_W      = 13;
   localparam int PROD_W     = 16;
   localparam int WIDTH_W    = 13;
   localparam int HEIGHT_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int BYTE_W     = 8;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   // Register reset values.
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

   // Quantiser and error arithmetic constants.
   localparam logic signed [PIX_W-1:0]  THRESHOLD   = 13'sd127;
   localparam logic signed [PIX_W-1:0]  WHITE_LEVEL = 13'sd255;
   localparam logic signed [SUM_W-1:0]  ERR_MAX     = 14'sd1023;
   localparam logic signed [SUM_W-1:0]  ERR_MIN     = -14'sd1024;
   localparam logic signed [PROD_W-1:0] DIV_BIAS    = 16'sd15;
   localparam int                       DIV_SHIFT   = 4;

   // Per-pixel position flags handed from the scan counters to the error stage.
   typedef struct packed {
      logic row_nz;
      logic last_col;
      logic last_row;
   } scan_ctl_type;

   // Saturate a widened sum to the 11-bit signed range of the error store.
   function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SUM_W-1:0] val);
      logic signed [ERR_W-1:0] res;
      if (val > ERR_MAX) begin
         res = ERR_MAX[ERR_W-1:0];
      end else if (val < ERR_MIN) begin
         res = ERR_MIN[ERR_W-1:0];
      end else begin
         res = val[ERR_W-1:0];
      end
      return res;
   endfunction

   // Divide by sixteen, truncating toward zero as integer division does.
   function automatic logic signed [PROD_W-1:0] div16_trunc(
      input logic signed [PROD_W-1:0] val);
      logic signed [PROD_W-1:0] res;
      if (val < 0) begin
         res = (val + DIV_BIAS) >>> DIV_SHIFT;
      end else begin
         res = val >>> DIV_SHIFT;
      end
      return res;
   endfunction

endpackage

### rtl/core/fsd_intf.sv
// Valid/ready channel interfaces for the mono dither unit: pixel input,
// packed byte output and configuration writes. Depends on fsd_pkg.
interface fsd_req_if;
   logic                      valid;
   logic                      ready;
   logic [fsd_pkg::GRAY_W-1:0] gray;
   modport source (output valid, gray, input ready);
   modport sink   (input valid, gray, output ready);
endinterface

interface fsd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [fsd_pkg::BYTE_W-1:0] mono_byte;
   logic                      end_of_row;
   logic                      end_of_image;
   modport source (output valid, mono_byte, end_of_row, end_of_image, input ready);
   modport sink   (input valid, mono_byte, end_of_row, end_of_image, output ready);
endinterface

interface fsd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [fsd_pkg::CSR_IDX_W-1:0]  index;
   logic [fsd_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/fsd_line_mem.sv
// Single-port-write, registered-read line store holding the error for the next row.
// Depends on fsd_pkg for the error width.
module fsd_line_mem #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                    clock,
   input  logic                                    rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]            rd_addr,
   output logic signed [fsd_pkg::ERR_W-1:0]        rd_data,
   input  logic                                    wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]            wr_addr,
   input  logic signed [fsd_pkg::ERR_W-1:0]        wr_data
);
   import fsd_pkg::*;

   logic signed [ERR_W-1:0] line_mem [MAX_WIDTH];
   logic signed [ERR_W-1:0] rd_data_ff;

   // Write port; a read of the same entry in the same cycle returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, loaded only when a transaction is taken.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/fsd_scan.sv
// Configuration registers and the column/row scan counters of the dither unit.
// Depends on fsd_pkg and fsd_csr_if.
module fsd_scan #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   fsd_csr_if.sink                       csr,
   input  logic                          accept,
   output logic [$clog2(MAX_WIDTH)-1:0]  s0_x,
   output fsd_pkg::scan_ctl_type         s0_ctl
);
   import fsd_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = (AW + 2 > WIDTH_W + 1) ? AW + 2 : WIDTH_W + 1;
   localparam int RW = HEIGHT_W + 1;

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [AW-1:0]       column_ff, column_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [CW-1:0]       width_ext, width_eff;
   logic [RW-1:0]       height_eff;
   logic                last_col, last_row;

   // Configuration writes are always taken; unknown indexes are ignored.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr.valid) begin
         if (csr.index == REG_IMAGE_WIDTH) begin
            width_ff <= csr.data[WIDTH_W-1:0];
         end else if (csr.index == REG_IMAGE_HEIGHT) begin
            height_ff <= csr.data[HEIGHT_W-1:0];
         end
      end
   end

   // Clamp the programmed geometry into its usable range.
   always_comb begin
      width_ext = CW'(width_ff);
      if (width_ext == '0) begin
         width_eff = CW'(1);
      end else if (width_ext > CW'(MAX_WIDTH)) begin
         width_eff = CW'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      height_eff = (height_ff == '0) ? RW'(1) : RW'(height_ff);
   end

   // Row and column end flags for the pixel at the head of the input.
   assign last_col = (CW'(column_ff) + CW'(1)) >= width_eff;
   assign last_row = (RW'(row_ff) + RW'(1)) >= height_eff;

   assign s0_x            = column_ff;
   assign s0_ctl.row_nz   = (row_ff != '0);
   assign s0_ctl.last_col = last_col;
   assign s0_ctl.last_row = last_row;

   // Advance the raster position once per accepted transaction.
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (last_col) begin
            column_in = '0;
            row_in    = last_row ? '0 : row_ff + HEIGHT_W'(1);
         end else begin
            column_in = column_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

### rtl/core/fsd_diffuse.sv
// Error stage of the dither unit: quantiser, error split, carries, line store
// write-back with forwarding, bit packing and the output register.
// Depends on fsd_pkg and fsd_rsp_if.
module fsd_diffuse #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   output logic                                 can_accept,
   input  logic [fsd_pkg::GRAY_W-1:0]           s0_gray,
   input  logic [$clog2(MAX_WIDTH)-1:0]         s0_x,
   input  fsd_pkg::scan_ctl_type                s0_ctl,
   input  logic signed [fsd_pkg::ERR_W-1:0]     rd_data,
   output logic                                 mem_we,
   output logic [$clog2(MAX_WIDTH)-1:0]         mem_waddr,
   output logic signed [fsd_pkg::ERR_W-1:0]     mem_wdata,
   fsd_rsp_if.source                            rsp
);
   import fsd_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   // Stage registers.
   logic                    s1_valid_ff, s1_valid_in;
   logic [GRAY_W-1:0]       s1_gray_ff;
   logic [AW-1:0]           s1_x_ff;
   scan_ctl_type            s1_ctl_ff;
   logic                    fwd_hit_ff, fwd_hit_in;
   logic signed [ERR_W-1:0] fwd_val_ff, fwd_val_in;

   // Error carries and the deferred end-of-row write.
   logic signed [ERR_W-1:0] right_carry_ff, right_carry_in;
   logic signed [ERR_W-1:0] pend0_ff, pend0_in;
   logic signed [ERR_W-1:0] pend1_ff, pend1_in;
   logic                    tail_valid_ff, tail_valid_in;
   logic [AW-1:0]           tail_addr_ff, tail_addr_in;
   logic signed [ERR_W-1:0] tail_val_ff, tail_val_in;
   logic [BYTE_W-1:0]       acc_ff, acc_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]       rsp_byte_ff;
   logic                    rsp_eor_ff, rsp_eoi_ff;

   // Datapath.
   logic signed [ERR_W-1:0]  err_above;
   logic signed [PIX_W-1:0]  pix_val, quant_err;
   logic signed [PROD_W-1:0] err_wide, q7, q3, q5, q1;
   logic signed [ERR_W-1:0]  left_val, mid_val;
   logic                     white, s1_emit, s1_adv;
   logic [BYTE_W-1:0]        acc_new;
   logic                     x_nz;
   logic                     c_tail_new, c_left, c_tail_old;

   assign x_nz = (s1_x_ff != '0);

   // Quantise the pixel with the error from above and from the left.
   always_comb begin
      if (!s1_ctl_ff.row_nz) begin
         err_above = '0;
      end else if (fwd_hit_ff) begin
         err_above = fwd_val_ff;
      end else begin
         err_above = rd_data;
      end
      pix_val = $signed({{(PIX_W-GRAY_W){1'b0}}, s1_gray_ff}) + PIX_W'(err_above)
                + (x_nz ? PIX_W'(right_carry_ff) : '0);
      white     = (pix_val > THRESHOLD);
      quant_err = pix_val - (white ? WHITE_LEVEL : '0);
   end

   // Split the error into its four weighted shares.
   always_comb begin
      err_wide = PROD_W'(quant_err);
      q7 = div16_trunc(err_wide * 16'sd7);
      q3 = div16_trunc(err_wide * 16'sd3);
      q5 = div16_trunc(err_wide * 16'sd5);
      q1 = div16_trunc(err_wide);
      left_val = sat_err(SUM_W'(pend0_ff) + SUM_W'(q3));
      mid_val  = sat_err(SUM_W'(pend1_ff) + SUM_W'(q5));
   end

   // Bit packing and the emit decision.
   assign acc_new = acc_ff | (BYTE_W'(white) << (3'd7 - s1_x_ff[2:0]));
   assign s1_emit = (s1_x_ff[2:0] == 3'd7) || s1_ctl_ff.last_col;

   // The stage moves on unless its result has nowhere to go.
   assign s1_adv     = s1_valid_ff && !(s1_emit && rsp_valid_ff && !rsp.ready);
   assign can_accept = !s1_valid_ff || s1_adv;

   // Line store write: left neighbour, or the held end-of-row word at column zero.
   always_comb begin
      mem_we    = s1_adv && (x_nz || tail_valid_ff);
      mem_waddr = x_nz ? s1_x_ff - AW'(1) : tail_addr_ff;
      mem_wdata = x_nz ? left_val : tail_val_ff;
   end

   // Carry and tail updates.
   always_comb begin
      right_carry_in = right_carry_ff;
      pend0_in       = pend0_ff;
      pend1_in       = pend1_ff;
      tail_valid_in  = tail_valid_ff;
      tail_addr_in   = tail_addr_ff;
      tail_val_in    = tail_val_ff;
      acc_in         = acc_ff;
      if (s1_adv) begin
         acc_in = s1_emit ? '0 : acc_new;
         if (!x_nz) begin
            tail_valid_in = 1'b0;
         end
         if (s1_ctl_ff.last_col) begin
            right_carry_in = '0;
            pend0_in       = '0;
            pend1_in       = '0;
            tail_valid_in  = 1'b1;
            tail_addr_in   = s1_x_ff;
            tail_val_in    = mid_val;
         end else begin
            right_carry_in = sat_err(SUM_W'(q7));
            pend0_in       = mid_val;
            pend1_in       = sat_err(SUM_W'(q1));
         end
      end
   end

   // Forwarding for a read that hits a word not yet in the line store.
   always_comb begin
      c_tail_new = s1_valid_ff && s1_ctl_ff.last_col && (s0_x == s1_x_ff);
      c_left     = s1_valid_ff && x_nz && (s0_x == s1_x_ff - AW'(1));
      c_tail_old = tail_valid_ff && (s0_x == tail_addr_ff);
      fwd_hit_in = c_tail_new || c_left || c_tail_old;
      priority if (c_tail_new) begin
         fwd_val_in = mid_val;
      end else if (c_left) begin
         fwd_val_in = left_val;
      end else begin
         fwd_val_in = tail_val_ff;
      end
   end

   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_adv && s1_emit) ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         tail_valid_ff  <= 1'b0;
         right_carry_ff <= '0;
         pend0_ff       <= '0;
         pend1_ff       <= '0;
         acc_ff         <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         tail_valid_ff  <= tail_valid_in;
         right_carry_ff <= right_carry_in;
         pend0_ff       <= pend0_in;
         pend1_ff       <= pend1_in;
         acc_ff         <= acc_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      tail_addr_ff <= tail_addr_in;
      tail_val_ff  <= tail_val_in;
      if (accept) begin
         s1_gray_ff <= s0_gray;
         s1_x_ff    <= s0_x;
         s1_ctl_ff  <= s0_ctl;
         fwd_hit_ff <= fwd_hit_in;
         fwd_val_ff <= fwd_val_in;
      end
      if (s1_adv && s1_emit) begin
         rsp_byte_ff <= acc_new;
         rsp_eor_ff  <= s1_ctl_ff.last_col;
         rsp_eoi_ff  <= s1_ctl_ff.last_col && s1_ctl_ff.last_row;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.mono_byte    = rsp_byte_ff;
   assign rsp.end_of_row   = rsp_eor_ff;
   assign rsp.end_of_image = rsp_eoi_ff;

   // A held end-of-row word is always flushed by the next pixel, at column zero.
   assert property (@(posedge clock) disable iff (reset)
      s1_adv && x_nz |-> !tail_valid_ff)
      else $error("held end-of-row word still pending past column zero");

   // The last pixel of a row clears the carries and leaves its word held.
   assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_ctl_ff.last_col |=> tail_valid_ff && right_carry_ff == '0
                                       && pend0_ff == '0 && pend1_ff == '0)
      else $error("row end did not reset the error carries");

   // A new transaction only enters when the stage ahead of it empties.
   assert property (@(posedge clock) disable iff (reset)
      accept && s1_valid_ff |-> s1_adv)
      else $error("transaction accepted over a stalled error stage");

   // A stalled stage keeps its pixel.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_x_ff) && $stable(acc_ff))
      else $error("stalled error stage lost its pixel");

endmodule

### rtl/core/floyd_steinberg_mono_dither_unit.sv
// Floyd-Steinberg 1-bit dither unit: top level joining scan counters, line store
// and error stage. Depends on fsd_pkg, the fsd_*_if interfaces and fsd_* modules.
//
// Gray pixels enter in raster order at one transaction per clock while the
// receiver keeps up, and leave as packed bytes (leftmost pixel in bit 7, white is
// 1), one byte per eight pixels and one at each row end. A taken pixel is
// registered into the error stage, where its error is worked out, and its byte, if
// any, is loaded into the output register when that stage moves on. The rate is
// set by the error carry to the right neighbour and by the single write port of
// the row error store (MAX_WIDTH words of 11 bits); the end-of-row word is held
// and written while the first pixel of the next row is processed, and reads that
// hit words not yet written are forwarded. The store needs no clearing after
// reset: the first row of every image ignores it. Width and height sit at indexes
// 0 and 1; the user must write them only while the unit is idle, which the block
// does not enforce, and they take effect from the next pixel.
module floyd_steinberg_mono_dither_unit #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   fsd_req_if.sink     req,
   fsd_rsp_if.source   rsp,
   fsd_csr_if.sink     csr
);
   import fsd_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic                    req_accept;
   logic                    can_accept;
   logic [AW-1:0]           s0_x;
   scan_ctl_type            s0_ctl;
   logic signed [ERR_W-1:0] rd_data;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic signed [ERR_W-1:0] mem_wdata;

   assign req.ready  = can_accept;
   assign req_accept = req.valid && can_accept;

   // Raster position and geometry registers.
   fsd_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .accept (req_accept),
      .s0_x   (s0_x),
      .s0_ctl (s0_ctl)
   );

   // Error line for the next row, read at the accepted pixel's column.
   fsd_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (s0_x),
      .rd_data (rd_data),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata)
   );

   // Quantiser, error diffusion and byte output.
   fsd_diffuse #(.MAX_WIDTH(MAX_WIDTH)) u_diffuse (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .can_accept (can_accept),
      .s0_gray    (req.gray),
      .s0_x       (s0_x),
      .s0_ctl     (s0_ctl),
      .rd_data    (rd_data),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .rsp        (rsp)
   );

endmodule

### verif/tb.sv
// Self-checking testbench for floyd_steinberg_mono_dither_unit: directed and
// random gray images are compared byte by byte against a dither predictor.
// Depends on fsd_pkg, the fsd_*_if channel interfaces and the unit's RTL.
module tb;

   // Sizes, arithmetic constants and timing of the run.
   localparam int LINE_DEPTH      = 4096;
   localparam int QUANT_THRESHOLD = 127;
   localparam int QUANT_WHITE     = 255;
   localparam int ERR_HI          = 1023;
   localparam int ERR_LO          = -1024;
   localparam int SETTLE_CYCLES   = 6;
   localparam int STALL_LIMIT     = 2000;
   localparam int ITEMS_PER_PHASE = 120;
   localparam int WIDE_CUT        = 96;

   // Register indexes with no register behind them.
   localparam logic [fsd_pkg::CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [fsd_pkg::CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;

   typedef struct packed {
      logic [fsd_pkg::BYTE_W-1:0] mono_byte;
      logic                       end_of_row;
      logic                       end_of_image;
   } mono_result_type;

   typedef enum int {TONE_UNIFORM, TONE_EXTREME, TONE_MIDGREY, TONE_FLAT} tone_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fsd_req_if req_if ();
   fsd_rsp_if rsp_if ();
   fsd_csr_if csr_if ();

   floyd_steinberg_mono_dither_unit #(
      .MAX_WIDTH(LINE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if),
      .csr  (csr_if)
   );

   // Predictor state: configuration, error line, carries, scan position and packing.
   logic [fsd_pkg::WIDTH_W-1:0]         cfg_width  = fsd_pkg::WIDTH_RESET;
   logic [fsd_pkg::HEIGHT_W-1:0]        cfg_height = fsd_pkg::HEIGHT_RESET;
   logic signed [fsd_pkg::ERR_W-1:0]    err_line [LINE_DEPTH];
   logic signed [fsd_pkg::ERR_W-1:0]    right_err = '0;
   logic signed [fsd_pkg::ERR_W-1:0]    pend_left = '0;
   logic signed [fsd_pkg::ERR_W-1:0]    pend_here = '0;
   logic [11:0]                         scan_col  = '0;
   logic [15:0]                         scan_row  = '0;
   logic [fsd_pkg::BYTE_W-1:0]          pack_bits = '0;

   mono_result_type expected_bytes [$];
   mono_result_type rsp_want;

   int errors        = 0;
   int pixels_sent   = 0;
   int bytes_checked = 0;
   int reg_writes    = 0;
   int images_done   = 0;
   int idle_pct      = 0;
   int stall_pct     = 0;
   int quiet_cycles  = 0;

   always #4 clock = ~clock;

   // Saturate a diffused error to the 11-bit signed range of the error line.
   function automatic logic signed [fsd_pkg::ERR_W-1:0] clamp_err(input int val);
      int res;
      res = val;
      if (res > ERR_HI) res = ERR_HI;
      if (res < ERR_LO) res = ERR_LO;
      return res[fsd_pkg::ERR_W-1:0];
   endfunction

   // Dither one accepted pixel and queue the byte it completes, if any.
   function automatic void predict_pixel(input logic [fsd_pkg::GRAY_W-1:0] gray);
      int              eff_w, eff_h, x, v, e, d3, d5, d1, r7;
      logic            last_col, last_row, white;
      mono_result_type res;
      eff_w = int'(cfg_width);
      if (eff_w < 1) eff_w = 1;
      if (eff_w > LINE_DEPTH) eff_w = LINE_DEPTH;
      eff_h = int'(cfg_height);
      if (eff_h < 1) eff_h = 1;
      x = int'(scan_col);
      last_col = (x + 1 >= eff_w);
      last_row = (int'(scan_row) + 1 >= eff_h);

      // Gather error from the row above and from the left neighbour.
      v = int'(gray);
      if (scan_row != 0) v = v + int'(err_line[x]);
      if (x > 0) v = v + int'(right_err);
      white = (v > QUANT_THRESHOLD);
      e = white ? v - QUANT_WHITE : v;

      // Each share truncates toward zero on its own.
      r7 = (7 * e) / 16;
      d3 = (3 * e) / 16;
      d5 = (5 * e) / 16;
      d1 = e / 16;

      if (x > 0) err_line[x - 1] = clamp_err(int'(pend_left) + d3);
      if (last_col) begin
         err_line[x] = clamp_err(int'(pend_here) + d5);
         right_err = '0;
         pend_left = '0;
         pend_here = '0;
      end else begin
         pend_left = clamp_err(int'(pend_here) + d5);
         pend_here = clamp_err(d1);
         right_err = clamp_err(r7);
      end

      // Pack most significant bit first; a byte leaves every eight pixels and at row end.
      if (white) pack_bits[7 - (x % 8)] = 1'b1;
      if (((x % 8) == 7) || last_col) begin
         res.mono_byte    = pack_bits;
         res.end_of_row   = last_col;
         res.end_of_image = last_col && last_row;
         expected_bytes.push_back(res);
         pack_bits = '0;
         if (res.end_of_image) images_done++;
      end

      if (last_col) begin
         scan_col = '0;
         scan_row = last_row ? '0 : scan_row + 1'b1;
      end else begin
         scan_col = scan_col + 1'b1;
      end
   endfunction

   function automatic logic [fsd_pkg::GRAY_W-1:0] pick_gray(input tone_type tone,
                                                           input logic [7:0] level);
      logic [fsd_pkg::GRAY_W-1:0] g;
      case (tone)
         TONE_EXTREME: g = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         TONE_MIDGREY: g = 8'($urandom_range(136, 120));
         TONE_FLAT:    g = level;
         default:      g = 8'($urandom);
      endcase
      return g;
   endfunction

   // Offer one pixel, idling at random first; valid stays high after the transaction.
   task automatic push_pixel(input logic [fsd_pkg::GRAY_W-1:0] gray);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.gray  <= gray;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_pixel(gray);
      pixels_sent++;
   endtask

   // Let every expected byte arrive, then give the pipeline time to empty.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [fsd_pkg::CSR_IDX_W-1:0]  index,
                            input logic [fsd_pkg::CSR_DATA_W-1:0] data);
      wait_idle();
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      if (index == fsd_pkg::REG_IMAGE_WIDTH) begin
         cfg_width = data[fsd_pkg::WIDTH_W-1:0];
      end else if (index == fsd_pkg::REG_IMAGE_HEIGHT) begin
         cfg_height = data;
      end
      reg_writes++;
   endtask

   // Send pixels of the given tone until the scan is back at the top left corner.
   task automatic finish_image(input tone_type tone, input logic [7:0] level);
      while (scan_row != 0 || scan_col != 0) push_pixel(pick_gray(tone, level));
   endtask

   // Reset sizes of 640 by 480: a full first row and part of the second, then shrink to end the image.
   task automatic test_reset_defaults();
      repeat (643) push_pixel(8'($urandom));
      write_csr(fsd_pkg::REG_IMAGE_HEIGHT, 16'd1);
      write_csr(fsd_pkg::REG_IMAGE_WIDTH, 16'd4);
      finish_image(TONE_UNIFORM, 8'h00);
   endtask

   // Black, white and the values either side of the threshold over three rows.
   task automatic test_tone_extremes();
      logic [7:0] tones [24];
      int         i;
      tones = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'd127, 8'd128, 8'h01, 8'hFE,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'd127, 8'd127, 8'd128, 8'd128, 8'h00, 8'h00, 8'h00, 8'h00};
      write_csr(fsd_pkg::REG_IMAGE_WIDTH, 16'd8);
      write_csr(fsd_pkg::REG_IMAGE_HEIGHT, 16'd3);
      for (i = 0; i < 24; i++) push_pixel(tones[i]);
   endtask

   // Zero sizes, ignored upper register bits, unused indexes and a padded last byte.
   task automatic test_degenerate_sizes();
      write_csr(fsd_pkg::REG_IMAGE_WIDTH, 16'd0);
      write_csr(fsd_pkg::REG_IMAGE_HEIGHT, 16'd0);
      repeat (3) push_pixel(8'($urandom));
      write_csr(fsd_pkg::REG_IMAGE_WIDTH, 16'hE001);
      write_csr(fsd_pkg::REG_IMAGE_HEIGHT, 16'd1);
      repeat (2) push_pixel(8'($urandom));
      write_csr(REG_SPARE_A, 16'hFFFF);
      write_csr(REG_SPARE_B, 16'h0000);
      repeat (2) push_pixel(8'($urandom));
      write_csr(fsd_pkg::REG_IMAGE_WIDTH, 16'd9);
      write_csr(fsd_pkg::REG_IMAGE_HEIGHT, 16'd2);
      repeat (18) push_pixel(8'($urandom));
   endtask

   // Sizes shrunk mid-image: the column is past the new width and the row past the height.
   task automatic test_mid_image_change();
      write_csr(fsd_pkg::REG_IMAGE_WIDTH, 16'd3);
      write_csr(fsd_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
      repeat (8) push_pixel(8'($urandom));
      write_csr(fsd_pkg::REG_IMAGE_WIDTH, 16'd2);
      write_csr(fsd_pkg::REG_IMAGE_HEIGHT, 16'd2);
      finish_image(TONE_UNIFORM, 8'h00);
   endtask

   // An oversized width held at the maximum, then cut short so the row ends early.
   task automatic test_wide_row_cut();
      write_csr(fsd_pkg::REG_IMAGE_WIDTH, 16'h1FFF);
      write_csr(fsd_pkg::REG_IMAGE_HEIGHT, 16'd2);
      repeat (WIDE_CUT) push_pixel(8'($urandom));
      write_csr(fsd_pkg::REG_IMAGE_WIDTH, 16'(WIDE_CUT));
      finish_image(TONE_UNIFORM, 8'h00);
   endtask

   // Random small images under four idling mixes, some cut short by a size change.
   task automatic test_random_images();
      int         phase, start, w, h, eff_w, eff_h, n, stop_at;
      tone_type   tone;
      logic [7:0] level;
      logic [2:0] junk;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 50; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 50; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         start = pixels_sent;
         while (pixels_sent - start < ITEMS_PER_PHASE) begin
            w = ($urandom_range(7) == 0) ? $urandom_range(200, 25) : $urandom_range(24, 1);
            h = (w > 24) ? $urandom_range(2, 1) : $urandom_range(5, 1);
            if ($urandom_range(15) == 0) w = 0;
            if ($urandom_range(15) == 0) h = 0;
            junk = 3'($urandom);
            write_csr(fsd_pkg::REG_IMAGE_WIDTH, {junk, 13'(w)});
            write_csr(fsd_pkg::REG_IMAGE_HEIGHT, 16'(h));
            eff_w = (w < 1) ? 1 : w;
            eff_h = (h < 1) ? 1 : h;
            n = eff_w * eff_h;
            tone  = tone_type'($urandom_range(3));
            level = 8'($urandom);
            stop_at = (n > 1 && $urandom_range(5) == 0) ? $urandom_range(n - 1, 1) : n;
            repeat (stop_at) push_pixel(pick_gray(tone, level));
            if (stop_at < n) begin
               write_csr(fsd_pkg::REG_IMAGE_WIDTH, 16'($urandom_range(eff_w, 1)));
               write_csr(fsd_pkg::REG_IMAGE_HEIGHT, 16'($urandom_range(eff_h, 1)));
               finish_image(tone, level);
            end
         end
      end
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   // Receiver: ready drops at random according to the current stall rate.
   initial rsp_if.ready = 1'b0;
   always @(posedge clock) begin
      rsp_if.ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   // Compare each byte transaction with the oldest expected byte.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_bytes.size() == 0) begin
            errors++;
            $error("unexpected byte %02h with no pixel awaiting it", rsp_if.mono_byte);
         end else begin
            rsp_want = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_if.mono_byte !== rsp_want.mono_byte) begin
               errors++;
               $error("mono_byte: expected %02h, got %02h", rsp_want.mono_byte,
                      rsp_if.mono_byte);
            end
            if (rsp_if.end_of_row !== rsp_want.end_of_row) begin
               errors++;
               $error("end_of_row: expected %0b, got %0b", rsp_want.end_of_row,
                      rsp_if.end_of_row);
            end
            if (rsp_if.end_of_image !== rsp_want.end_of_image) begin
               errors++;
               $error("end_of_image: expected %0b, got %0b", rsp_want.end_of_image,
                      rsp_if.end_of_image);
            end
         end
      end
   end

   // Watchdog: too many cycles without any transaction on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timed out after %0d cycles with no transaction.", STALL_LIMIT);
         $display("floyd_steinberg_mono_dither_unit verification failed");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      req_if.valid = 1'b0;
      req_if.gray  = '0;
      csr_if.valid = 1'b0;
      csr_if.index = fsd_pkg::REG_IMAGE_WIDTH;
      csr_if.data  = '0;
      foreach (err_line[i]) err_line[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_tone_extremes();
      test_degenerate_sizes();
      test_mid_image_change();
      test_wide_row_cut();
      test_random_images();

      wait_idle();
      if (expected_bytes.size() != 0) begin
         errors += expected_bytes.size();
         $error("%0d expected bytes never arrived", expected_bytes.size());
      end
      $display("Dithered %0d pixels over %0d images with %0d register writes;",
               pixels_sent, images_done, reg_writes);
      $display("%0d bytes checked, zero, small and oversized widths, four idling mixes.",
               bytes_checked);
      if (errors == 0) begin
         $display("floyd_steinberg_mono_dither_unit verification clean");
      end else begin
         $display("floyd_steinberg_mono_dither_unit verification failed");
      end
      $finish;
   end

endmodule
